/* design/perm_enum_pkg.sv */
// Shared types, codes and defaults for the permutation enumerator.
package perm_enum_pkg;

  localparam int MAX_LEN_DEF     = 20;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int OPCODE_W = 2;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 62;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_NEXT  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_LEN_ERR   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_K_SCAN,
    ST_L_SCAN,
    ST_REV_RD,
    ST_REV_WR,
    ST_SCAN,
    ST_COUNT
  } state_t;

  // Address source for the single read port of the position array.
  typedef enum logic [1:0] {
    RD_LAST,
    RD_IDX,
    RD_A,
    RD_B
  } rd_sel_t;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic                init;
    logic                k_start;
    logic                k_step;
    logic                l_step;
    logic                rev_read;
    logic                rev_write;
    logic                scan_start;
    logic                scan_step;
    logic                push_sym;
    logic                push_single;
    logic [STATUS_W-1:0] status;
    rd_sel_t             rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic len_lt2;
    logic len_full;
    logic started;
    logic finished;
    logic k_found;
    logic l_found;
    logic rev_done;
    logic scan_last;
    logic out_free;
    logic emit_en;
  } dp_stat_t;

endpackage

/* design/permutation_enumerator.sv */
// Top level of the permutation enumerator: stream ports, controller and datapath.
//
//   channel   direction  signals                          payload
//   s_axis    in         tvalid tready tdata[15:0]        opcode, symbol
//   m_axis    out        tvalid tready tdata[71:0] tlast  out_symbol, perm_count, last
//                        tuser[1:0]                       status
//   cfg       in         cfg_we cfg_wdata                 emit_strings
//
// Clear and load finish in the idle state; an error or count-only result waits for a free output.
// Over the single read port of the position array, a request runs the pivot search, the
// swap-partner search, the tail reversal (a read and a write per swap) and the scan; the
// first request only scans. One symbol leaves per cycle while the output is not stalled.
// Reset (rst, synchronous) empties the store, clears the count and sets emit_strings.
// A stalled output holds the scan while strings are emitted; a new transfer is taken only between requests.
module permutation_enumerator import perm_enum_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] opcode, [9:2] symbol, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] out_symbol, [69:8] perm_count, rest zero
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [SYM_W-1:0]    out_symbol;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;

  perm_enum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .opcode   (s_axis_tdata[1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  perm_enum_dp #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .symbol     (s_axis_tdata[9:2]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_symbol (out_symbol),
    .out_last   (m_axis_tlast),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign m_axis_tdata = {2'b00, out_count, out_symbol};
  assign m_axis_tuser = out_status;

endmodule

/* design/perm_enum_dp.sv */
// Datapath: symbol store, position array, scan registers, count and output register.
module perm_enum_dp import perm_enum_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYM_W-1:0]    out_symbol,
  output logic                out_last,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [SYMBOL_BITS-1:0] store [MAX_LEN];
  logic [IDX_W-1:0]       po [MAX_LEN];

  logic [LEN_W-1:0]   len;
  logic               started;
  logic               finished;
  logic               emit_strings;
  logic [COUNT_W-1:0] count;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] a;
  logic [IDX_W-1:0] b;
  logic [IDX_W-1:0] prev;
  logic [IDX_W-1:0] pk;
  logic [IDX_W-1:0] tmp;
  logic             asc;

  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       rd;
  logic [SYMBOL_BITS-1:0] sym_rd;
  logic                   step_asc;
  logic                   out_free;

  assign last_idx = IDX_W'(len - LEN_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      RD_LAST: rd_addr = last_idx;
      RD_IDX:  rd_addr = idx;
      RD_A:    rd_addr = a;
      RD_B:    rd_addr = b;
      default: rd_addr = idx;
    endcase
  end

  assign rd       = po[rd_addr];
  assign sym_rd   = store[rd];
  assign step_asc = (idx != '0) && (prev < rd);
  assign out_free = !out_valid || out_ready;

  assign stat.len_lt2   = len < LEN_W'(2);
  assign stat.len_full  = len == LEN_W'(MAX_LEN);
  assign stat.started   = started;
  assign stat.finished  = finished;
  assign stat.k_found   = rd < prev;
  assign stat.l_found   = rd > pk;
  assign stat.rev_done  = a >= b;
  assign stat.scan_last = idx == last_idx;
  assign stat.out_free  = out_free;
  assign stat.emit_en   = emit_strings;

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      started      <= 1'b0;
      finished     <= 1'b0;
      emit_strings <= 1'b1;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        emit_strings <= cfg_wdata;
      end
      if (cmd.clear) begin
        len      <= '0;
        started  <= 1'b0;
        finished <= 1'b0;
        count    <= '0;
      end
      if (cmd.load) begin
        len      <= len + 1'b1;
        started  <= 1'b0;
        finished <= 1'b0;
      end
      if (cmd.init) begin
        started <= 1'b1;
      end
      if (cmd.scan_start) begin
        count <= count + 1'b1;
      end
      // The enumeration is done once the emitted order has no ascent left.
      if (cmd.scan_step && stat.scan_last) begin
        finished <= !(asc || step_asc);
      end
      if (cmd.push_sym || cmd.push_single) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[len[IDX_W-1:0]] <= SYMBOL_BITS'(symbol);
    end
    if (cmd.init) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        po[i] <= IDX_W'(i);
      end
    end
    if (cmd.k_start) begin
      prev <= rd;
      idx  <= IDX_W'(len - LEN_W'(2));
    end
    // Pivot search runs from the right end toward the front.
    if (cmd.k_step) begin
      if (stat.k_found) begin
        k   <= idx;
        pk  <= rd;
        idx <= last_idx;
      end else begin
        prev <= rd;
        idx  <= idx - 1'b1;
      end
    end
    if (cmd.l_step) begin
      if (stat.l_found) begin
        po[k]   <= rd;
        po[idx] <= pk;
        a       <= k + 1'b1;
        b       <= last_idx;
      end else begin
        idx <= idx - 1'b1;
      end
    end
    if (cmd.rev_read) begin
      tmp <= rd;
    end
    if (cmd.rev_write) begin
      po[a] <= rd;
      po[b] <= tmp;
      a     <= a + 1'b1;
      b     <= b - 1'b1;
    end
    if (cmd.scan_start) begin
      idx <= '0;
      asc <= 1'b0;
    end
    if (cmd.scan_step) begin
      asc  <= asc || step_asc;
      prev <= rd;
      idx  <= idx + 1'b1;
    end
    if (cmd.push_sym) begin
      out_symbol <= SYM_W'(sym_rd);
      out_last   <= stat.scan_last;
      out_status <= STAT_OK;
      out_count  <= count;
    end else if (cmd.push_single) begin
      out_symbol <= '0;
      out_last   <= 1'b1;
      out_status <= cmd.status;
      out_count  <= count;
    end
  end

endmodule

/* design/perm_enum_ctrl.sv */
// Controller: decodes input transfers and sequences the datapath through each request.
module perm_enum_ctrl import perm_enum_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  dp_stat_t            stat,
  output dp_cmd_t             cmd
);

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      res_status <= STAT_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_LOAD: begin
              if (stat.len_full) begin
                state_next      = ST_SINGLE;
                res_status_next = STAT_OVERFLOW;
              end
            end
            OP_NEXT: begin
              if (stat.len_lt2) begin
                state_next      = ST_SINGLE;
                res_status_next = STAT_LEN_ERR;
              end else if (stat.finished) begin
                state_next      = ST_SINGLE;
                res_status_next = STAT_EXHAUSTED;
              end else begin
                res_status_next = STAT_OK;
                state_next      = stat.started ? ST_K_SCAN : ST_SCAN;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SINGLE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_K_SCAN: begin
        if (stat.k_found) state_next = ST_L_SCAN;
      end
      ST_L_SCAN: begin
        if (stat.l_found) state_next = ST_REV_RD;
      end
      ST_REV_RD: begin
        state_next = stat.rev_done ? ST_SCAN : ST_REV_WR;
      end
      ST_REV_WR: begin
        state_next = ST_REV_RD;
      end
      ST_SCAN: begin
        if ((!stat.emit_en || stat.out_free) && stat.scan_last) begin
          state_next = stat.emit_en ? ST_IDLE : ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = res_status;
    cmd.rd_sel = RD_IDX;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.rd_sel = RD_LAST;
        if (in_valid) begin
          case (opcode)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD:  cmd.load  = !stat.len_full;
            OP_NEXT: begin
              if (!stat.len_lt2 && !stat.finished) begin
                if (stat.started) begin
                  cmd.k_start = 1'b1;
                end else begin
                  cmd.init       = 1'b1;
                  cmd.scan_start = 1'b1;
                end
              end
            end
            default: cmd.clear = 1'b0;
          endcase
        end
      end
      ST_SINGLE: cmd.push_single = stat.out_free;
      ST_K_SCAN: cmd.k_step = 1'b1;
      ST_L_SCAN: cmd.l_step = 1'b1;
      ST_REV_RD: begin
        cmd.rd_sel = RD_A;
        if (stat.rev_done) begin
          cmd.scan_start = 1'b1;
        end else begin
          cmd.rev_read = 1'b1;
        end
      end
      ST_REV_WR: begin
        cmd.rd_sel    = RD_B;
        cmd.rev_write = 1'b1;
      end
      ST_SCAN: begin
        if (stat.emit_en) begin
          cmd.scan_step = stat.out_free;
          cmd.push_sym  = stat.out_free;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_COUNT: begin
        cmd.status      = STAT_OK;
        cmd.push_single = stat.out_free;
      end
      default: cmd.rd_sel = RD_IDX;
    endcase
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the permutation enumerator: stream driver, monitor and predictor.
module testbench;
  import perm_enum_pkg::*;

  localparam int MAX_SYMBOLS = MAX_LEN_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [SYM_W-1:0]    sym;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0]    sym;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [1:0] opcode, [9:2] symbol, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [7:0] out_symbol, [69:8] perm_count, rest zero
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;        // [1:0] status
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   on_bus;
  int      queued_count = 0;
  int      accepted_count = 0;
  int      errors = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // Predictor state.
  logic               emit_mode = 1'b1;
  logic [SYM_W-1:0]   sym_store[MAX_SYMBOLS];
  int                 store_len = 0;
  logic [4:0]         perm_pos[MAX_SYMBOLS];
  logic               enum_started = 1'b0;
  logic               enum_done = 1'b0;
  logic [COUNT_W-1:0] perm_total = '0;

  permutation_enumerator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void expect_single(input logic [STATUS_W-1:0] status);
    result_t r;
    r.sym = '0;
    r.last = 1'b1;
    r.status = status;
    r.count = perm_total;
    expected_results.push_back(r);
  endfunction

  function automatic void enumerate_item(input item_t it);
    result_t    r;
    int         i, k, l, a, b;
    logic       ascent;
    logic [4:0] t;
    case (it.op)
      OP_CLEAR: begin
        store_len = 0;
        enum_started = 1'b0;
        enum_done = 1'b0;
        perm_total = '0;
      end
      OP_LOAD: begin
        if (store_len >= MAX_SYMBOLS) begin
          expect_single(STAT_OVERFLOW);
        end else begin
          sym_store[store_len] = it.sym;
          store_len++;
          enum_started = 1'b0;
          enum_done = 1'b0;
        end
      end
      OP_NEXT: begin
        if (store_len < 2) begin
          expect_single(STAT_LEN_ERR);
        end else if (enum_done) begin
          expect_single(STAT_EXHAUSTED);
        end else begin
          if (!enum_started) begin
            for (i = 0; i < store_len; i++) perm_pos[i] = 5'(i);
            enum_started = 1'b1;
          end else begin
            // Rightmost ascent k, rightmost position above it, swap, then reverse the tail.
            k = 0;
            l = 0;
            for (i = 0; i + 1 < store_len; i++) begin
              if (perm_pos[i] < perm_pos[i+1]) k = i;
            end
            for (i = k + 1; i < store_len; i++) begin
              if (perm_pos[k] < perm_pos[i]) l = i;
            end
            t = perm_pos[k];
            perm_pos[k] = perm_pos[l];
            perm_pos[l] = t;
            a = k + 1;
            b = store_len - 1;
            while (a < b) begin
              t = perm_pos[a];
              perm_pos[a] = perm_pos[b];
              perm_pos[b] = t;
              a++;
              b--;
            end
          end
          ascent = 1'b0;
          for (i = 0; i + 1 < store_len; i++) begin
            if (perm_pos[i] < perm_pos[i+1]) ascent = 1'b1;
          end
          if (!ascent) enum_done = 1'b1;
          perm_total = perm_total + 1'b1;
          if (!emit_mode) begin
            expect_single(STAT_OK);
          end else begin
            for (i = 0; i < store_len; i++) begin
              r.sym = sym_store[perm_pos[i]];
              r.last = (i == store_len - 1);
              r.status = STAT_OK;
              r.count = perm_total;
              expected_results.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: presents queued items and feeds every accepted transfer to the predictor.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        enumerate_item(on_bus);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, on_bus.sym, on_bus.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sym = m_axis_tdata[7:0];
        got.last = m_axis_tlast;
        got.status = m_axis_tuser;
        got.count = m_axis_tdata[69:8];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result sym %02h last %0d status %0d count %0d",
                   $time, got.sym, got.last, got.status, got.count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.sym !== want.sym || got.last !== want.last ||
              got.status !== want.status || got.count !== want.count) begin
            $display("%0t: mismatch, expected sym %02h last %0d status %0d count %0d",
                     $time, want.sym, want.last, want.status, want.count);
            $display("%0t:           actual sym %02h last %0d status %0d count %0d",
                     $time, got.sym, got.last, got.status, got.count);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_item(input logic [OPCODE_W-1:0] op, input logic [SYM_W-1:0] sym);
    item_t it;
    it.op = op;
    it.sym = sym;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Waits until every item is taken and every result has come, then lets the block settle.
  task automatic drain();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_emit(input logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    emit_mode = value;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Mostly clear / load / request runs; the rest is single random transfers.
  task automatic queue_random_batch(input int target);
    int               added, len, reqs, roll, j;
    logic             narrow;
    logic [SYM_W-1:0] base;
    added = 0;
    while (added < target) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) != 0) begin
          add_item(OP_CLEAR, 8'($urandom));
          added++;
        end
        roll = $urandom_range(99);
        if (roll < 8) len = $urandom_range(1);
        else if (roll < 85) len = $urandom_range(4, 2);
        else if (roll < 95) len = $urandom_range(8, 5);
        else len = $urandom_range(22, 18);
        // A narrow alphabet gives repeated symbols.
        narrow = $urandom_range(1);
        base = 8'($urandom);
        for (j = 0; j < len; j++) begin
          add_item(OP_LOAD, narrow ? base + 8'($urandom_range(1)) : 8'($urandom));
          added++;
        end
        reqs = (len <= 3) ? $urandom_range(8, 1) : $urandom_range(4, 1);
        for (j = 0; j < reqs; j++) begin
          if ($urandom_range(11) == 0) add_item(OP_LOAD, 8'($urandom));
          else add_item(OP_NEXT, 8'($urandom));
          added++;
        end
      end else begin
        roll = $urandom_range(3);
        add_item(2'(roll), 8'($urandom));
        if (2'(roll) != OP_UNUSED) added++;
      end
    end
  endtask

  initial begin
    int j;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_item(OP_NEXT, 8'h00);
    add_item(OP_LOAD, 8'h00);
    add_item(OP_NEXT, 8'hFF);
    add_item(OP_LOAD, 8'hFF);
    // Two orders of two symbols, then the enumeration is exhausted.
    repeat (3) add_item(OP_NEXT, 8'h00);
    add_item(OP_UNUSED, 8'hFF);
    for (j = 2; j < MAX_SYMBOLS; j++) add_item(OP_LOAD, 8'($urandom));
    add_item(OP_LOAD, 8'h5A);
    repeat (2) add_item(OP_NEXT, 8'h00);
    add_item(OP_CLEAR, 8'h00);
    add_item(OP_NEXT, 8'h00);
    drain();

    write_emit(1'b1);
    set_idling(48, 0);
    queue_random_batch(50);
    drain();

    write_emit(1'b0);
    set_idling(0, 48);
    queue_random_batch(30);
    drain();

    write_emit(1'b1);
    set_idling(21, 21);
    queue_random_batch(50);
    drain();

    write_emit(1'b0);
    set_idling(0, 0);
    queue_random_batch(15);
    drain();

    write_emit(1'b1);
    queue_random_batch(15);
    drain();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
